// File: hdl/mvpc_pkg.sv
// Shared types and constants for the motor velocity PID controller.
package mvpc_pkg;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_TARGET = 2'd1,
    KIND_OPEN   = 2'd2,
    KIND_LOCK   = 2'd3
  } kind_t;

  localparam logic [2:0] REG_ACCEL = 3'd0;
  localparam logic [2:0] REG_GAIN_P = 3'd1;
  localparam logic [2:0] REG_GAIN_I = 3'd2;
  localparam logic [2:0] REG_GAIN_D = 3'd3;
  localparam logic [2:0] REG_SCALE = 3'd4;

  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 24;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  localparam logic [23:0] RECIP_1000 = 24'd4294967;
  localparam logic [32:0] MS_PER_S = 33'd1000;

  localparam logic [19:0] BAND_0 = 20'd419;
  localparam logic [19:0] BAND_1 = 20'd1259;
  localparam logic [19:0] BAND_2 = 20'd2099;
  localparam logic [19:0] BAND_3 = 20'd2939;
  localparam logic [19:0] BAND_4 = 20'd3779;
  localparam logic [19:0] BAND_5 = 20'd4199;

  localparam logic [2:0] LEVEL_OVER = 3'd6;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_STEP = 14'b00000000000010,
    S_CORR = 14'b00000000000100,
    S_RAMP = 14'b00000000001000,
    S_MOVE = 14'b00000000010000,
    S_ERR  = 14'b00000000100000,
    S_MP   = 14'b00000001000000,
    S_MI   = 14'b00000010000000,
    S_MD   = 14'b00000100000000,
    S_SUM  = 14'b00001000000000,
    S_UPD  = 14'b00010000000000,
    S_DRV  = 14'b00100000000000,
    S_BAND = 14'b01000000000000,
    S_EMIT = 14'b10000000000000
  } state_t;

endpackage

// File: hdl/mvpc_mul.sv
// Shared signed multiplier with registered product.
module mvpc_mul (
  input  logic                                   clk,
  input  mvpc_pkg::mul_req_t                     req,
  output logic signed [mvpc_pkg::PROD_W-1:0]     prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
  end

endmodule

// File: hdl/motor_velocity_pid_controller_unit.sv
// Top level: sequencer and datapath of the motor velocity PID controller.
//
// A command request (set target, set open-loop drive, lock) updates state at
// acceptance and then goes through the emit state to the output register; no
// new request is taken before it has left the emit state. A tick request walks a
// thirteen-step sequence after acceptance around the one shared 18x24 multiplier:
// ramp step (reciprocal multiply and correction), ramp move, error terms, the
// three gain products, accumulator update, drive scaling, banding and emit;
// in_tready stays low until the emit state has passed the result on. The
// result sits in an output register, so a new request is taken while it waits;
// a finished item stalls only if the previous result has not been taken.
module motor_velocity_pid_controller_unit #(
  parameter int FULL_SCALE_PWM = 4200,
  parameter int STALL_LIMIT = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] command_value, [31:16] encoder_delta
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // [12:0] compare_value, [26:13] drive_level, [27] turn_clockwise,
  // [30:28] speed_level, [31] overspeed_flag, [32] encoder_healthy,
  // [33] loop_closed, [49:34] velocity_now, [55:50] zero
  output logic [55:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int SCW = $clog2(STALL_LIMIT + 2);
  localparam int HW = 18;
  localparam logic [SCW-1:0] STALL_MAX = SCW'(STALL_LIMIT);
  localparam logic [SCW-1:0] STALL_DEAD = SCW'(STALL_LIMIT + 1);
  localparam logic signed [HW-1:0] FSP_S = HW'(FULL_SCALE_PWM);
  localparam logic [HW-1:0] FSP_U = HW'(FULL_SCALE_PWM);

  mvpc_pkg::state_t state_r, state_nxt;
  mvpc_pkg::mul_req_t mreq;
  logic signed [mvpc_pkg::PROD_W-1:0] prod_r;

  logic [15:0] accel_r, scale_r;
  logic signed [15:0] gp_r, gi_r, gd_r;

  logic signed [15:0] delta_r, delta_nxt;
  logic signed [31:0] ramp_r, ramp_nxt;
  logic signed [15:0] goal_r, goal_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [16:0] el_r, el_nxt, ebl_r, ebl_nxt;
  logic [SCW-1:0] stall_r, stall_nxt;
  logic healthy_r, healthy_nxt, closed_r, closed_nxt, cw_r, cw_nxt, over_r, over_nxt;
  logic signed [HW-1:0] held_r, held_nxt;
  logic [2:0] level_r, level_nxt;
  logic [22:0] q0_r, q0_nxt;
  logic [23:0] step_r, step_nxt;
  logic signed [16:0] e_r, e_nxt;
  logic signed [17:0] dp_r, dp_nxt;
  logic signed [19:0] dd_r, dd_nxt;
  logic signed [39:0] pid_r, pid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [55:0] out_data_r, out_data_nxt;

  logic [15:0] a_eff;
  logic in_fire;
  mvpc_pkg::kind_t in_kind;
  logic signed [15:0] in_cmd, in_delta;

  logic [32:0] rem;
  logic signed [33:0] diff;
  logic [33:0] diff_mag;
  logic signed [15:0] fl;
  logic signed [48:0] acc_sum;
  logic signed [31:0] acc_sat;
  logic [SCW-1:0] stall_inc;
  logic signed [33:0] dprod, dbias;
  logic signed [19:0] dval;
  logic [19:0] dmag;
  logic [HW-1:0] hmag;
  logic [HW-1:0] cmp_full;

  assign a_eff = (accel_r == 16'd0) ? 16'd1 : accel_r;
  assign in_tready = (state_r == mvpc_pkg::S_IDLE);
  assign in_fire = in_tvalid && in_tready;
  assign in_kind = mvpc_pkg::kind_t'(in_tuser);
  assign in_cmd = in_tdata[15:0];
  assign in_delta = in_tdata[31:16];
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  mvpc_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= 16'd100;
      gp_r <= '0;
      gi_r <= '0;
      gd_r <= '0;
      scale_r <= 16'd16384;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        mvpc_pkg::REG_ACCEL:  accel_r <= cfg_wdata;
        mvpc_pkg::REG_GAIN_P: gp_r <= cfg_wdata;
        mvpc_pkg::REG_GAIN_I: gi_r <= cfg_wdata;
        mvpc_pkg::REG_GAIN_D: gd_r <= cfg_wdata;
        mvpc_pkg::REG_SCALE:  scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    mreq.a = '0;
    mreq.b = '0;
    unique case (state_r)
      mvpc_pkg::S_STEP: begin
        mreq.a = {2'b00, a_eff};
        mreq.b = mvpc_pkg::RECIP_1000;
      end
      mvpc_pkg::S_CORR: begin
        mreq.a = 18'sd1000;
        mreq.b = {1'b0, prod_r[38:16]};
      end
      mvpc_pkg::S_MP: begin
        mreq.a = 18'(gp_r);
        mreq.b = 24'(dp_r);
      end
      mvpc_pkg::S_MI: begin
        mreq.a = 18'(gi_r);
        mreq.b = 24'(e_r);
      end
      mvpc_pkg::S_MD: begin
        mreq.a = 18'(gd_r);
        mreq.b = 24'(dd_r);
      end
      mvpc_pkg::S_DRV: begin
        mreq.a = 18'($signed(acc_r[31:16]));
        mreq.b = {8'h00, scale_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    rem = {1'b0, a_eff, 16'h0000} - prod_r[32:0];
    diff = $signed({{2{goal_r[15]}}, goal_r, 16'h0000}) - $signed({{2{ramp_r[31]}}, ramp_r});
    diff_mag = diff[33] ? 34'(-diff) : 34'(diff);
    fl = ramp_r[31:16];
    acc_sum = 49'(acc_r) + 49'($signed({pid_r, 8'h00}));
    if (acc_sum > 49'sd2147483647) begin
      acc_sat = 32'sh7fffffff;
    end else if (acc_sum < -49'sd2147483648) begin
      acc_sat = 32'sh80000000;
    end else begin
      acc_sat = acc_sum[31:0];
    end
    stall_inc = stall_r + SCW'(1);
    dprod = prod_r[33:0];
    dbias = dprod[33] ? dprod + 34'sd16383 : dprod;
    dval = 20'(dbias >>> 14);
    dmag = dval[19] ? 20'(-dval) : 20'(dval);
    hmag = held_r[HW-1] ? HW'(-held_r) : HW'(held_r);
    if (hmag > FSP_U) hmag = FSP_U;
    cmp_full = FSP_U - hmag;
  end

  always_comb begin
    state_nxt = state_r;
    delta_nxt = delta_r;
    ramp_nxt = ramp_r;
    goal_nxt = goal_r;
    acc_nxt = acc_r;
    el_nxt = el_r;
    ebl_nxt = ebl_r;
    stall_nxt = stall_r;
    healthy_nxt = healthy_r;
    closed_nxt = closed_r;
    cw_nxt = cw_r;
    over_nxt = over_r;
    held_nxt = held_r;
    level_nxt = level_r;
    q0_nxt = q0_r;
    step_nxt = step_r;
    e_nxt = e_r;
    dp_nxt = dp_r;
    dd_nxt = dd_r;
    pid_nxt = pid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;

    unique case (state_r)
      mvpc_pkg::S_IDLE: begin
        if (in_fire) begin
          delta_nxt = in_delta;
          state_nxt = mvpc_pkg::S_EMIT;
          unique case (in_kind)
            mvpc_pkg::KIND_TICK: state_nxt = mvpc_pkg::S_STEP;
            mvpc_pkg::KIND_TARGET: begin
              goal_nxt = in_cmd;
              closed_nxt = 1'b1;
            end
            mvpc_pkg::KIND_OPEN: begin
              acc_nxt = {in_cmd, 16'h0000};
              closed_nxt = 1'b0;
            end
            mvpc_pkg::KIND_LOCK: begin
              goal_nxt = '0;
              ramp_nxt = '0;
              closed_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      mvpc_pkg::S_STEP: state_nxt = mvpc_pkg::S_CORR;
      mvpc_pkg::S_CORR: begin
        q0_nxt = prod_r[38:16];
        state_nxt = mvpc_pkg::S_RAMP;
      end
      mvpc_pkg::S_RAMP: begin
        step_nxt = {1'b0, q0_r} + ((rem >= mvpc_pkg::MS_PER_S) ? 24'd1 : 24'd0);
        state_nxt = mvpc_pkg::S_MOVE;
      end
      mvpc_pkg::S_MOVE: begin
        if (diff_mag > {10'h000, step_r}) begin
          ramp_nxt = diff[33] ? ramp_r - {8'h00, step_r} : ramp_r + {8'h00, step_r};
        end else begin
          ramp_nxt = {goal_r, 16'h0000};
        end
        state_nxt = mvpc_pkg::S_ERR;
      end
      mvpc_pkg::S_ERR: begin
        e_nxt = 17'(fl) - 17'(delta_r);
        dp_nxt = 18'(17'(fl) - 17'(delta_r)) - 18'(el_r);
        dd_nxt = 20'(17'(fl) - 17'(delta_r)) + 20'(ebl_r) - (20'(el_r) <<< 1);
        state_nxt = mvpc_pkg::S_MP;
      end
      mvpc_pkg::S_MP: state_nxt = mvpc_pkg::S_MI;
      mvpc_pkg::S_MI: begin
        pid_nxt = 40'($signed(prod_r[37:0]));
        state_nxt = mvpc_pkg::S_MD;
      end
      mvpc_pkg::S_MD: begin
        pid_nxt = pid_r + 40'($signed(prod_r[37:0]));
        state_nxt = mvpc_pkg::S_SUM;
      end
      mvpc_pkg::S_SUM: begin
        pid_nxt = pid_r + 40'($signed(prod_r[37:0]));
        state_nxt = mvpc_pkg::S_UPD;
      end
      mvpc_pkg::S_UPD: begin
        el_nxt = e_r;
        ebl_nxt = el_r;
        if (closed_r && healthy_r) begin
          if (fl != 16'sd0 && delta_r == 16'sd0) begin
            stall_nxt = stall_inc;
            healthy_nxt = (stall_inc <= STALL_MAX);
          end else begin
            stall_nxt = '0;
          end
          acc_nxt = acc_sat;
        end else begin
          if (closed_r) acc_nxt = '0;
          if (healthy_r) begin
            goal_nxt = delta_r;
            ramp_nxt = {delta_r, 16'h0000};
            el_nxt = '0;
          end else if (delta_r != 16'sd0) begin
            stall_nxt = '0;
            healthy_nxt = 1'b1;
          end
        end
        state_nxt = mvpc_pkg::S_DRV;
      end
      mvpc_pkg::S_DRV: state_nxt = mvpc_pkg::S_BAND;
      mvpc_pkg::S_BAND: begin
        held_nxt = HW'(dval);
        priority if (dmag <= mvpc_pkg::BAND_0) level_nxt = 3'd0;
        else if (dmag <= mvpc_pkg::BAND_1) level_nxt = 3'd1;
        else if (dmag <= mvpc_pkg::BAND_2) level_nxt = 3'd2;
        else if (dmag <= mvpc_pkg::BAND_3) level_nxt = 3'd3;
        else if (dmag <= mvpc_pkg::BAND_4) level_nxt = 3'd4;
        else if (dmag <= mvpc_pkg::BAND_5) level_nxt = 3'd5;
        else begin
          level_nxt = mvpc_pkg::LEVEL_OVER;
          over_nxt = 1'b1;
          held_nxt = dval[19] ? -FSP_S : FSP_S;
        end
        if (dval > 20'sd0) cw_nxt = 1'b1;
        else if (dval < 20'sd0) cw_nxt = 1'b0;
        state_nxt = mvpc_pkg::S_EMIT;
      end
      mvpc_pkg::S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = {6'h00, ramp_r[31:16], closed_r, healthy_r, over_r, level_r,
                          cw_r, held_r[13:0], cmp_full[12:0]};
          state_nxt = mvpc_pkg::S_IDLE;
        end
      end
      default: state_nxt = mvpc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mvpc_pkg::S_IDLE;
      ramp_r <= '0;
      goal_r <= '0;
      acc_r <= '0;
      el_r <= '0;
      ebl_r <= '0;
      stall_r <= '0;
      healthy_r <= 1'b1;
      closed_r <= 1'b0;
      cw_r <= 1'b1;
      over_r <= 1'b0;
      held_r <= '0;
      level_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ramp_r <= ramp_nxt;
      goal_r <= goal_nxt;
      acc_r <= acc_nxt;
      el_r <= el_nxt;
      ebl_r <= ebl_nxt;
      stall_r <= stall_nxt;
      healthy_r <= healthy_nxt;
      closed_r <= closed_nxt;
      cw_r <= cw_nxt;
      over_r <= over_nxt;
      held_r <= held_nxt;
      level_r <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delta_r <= delta_nxt;
    q0_r <= q0_nxt;
    step_r <= step_nxt;
    e_r <= e_nxt;
    dp_r <= dp_nxt;
    dd_r <= dd_nxt;
    pid_r <= pid_nxt;
    out_data_r <= out_data_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("accepted request did not leave idle");

  a_over_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(over_r))
    else $error("overspeed flag cleared outside reset");

  a_stall_dead: assert property (@(posedge clk) disable iff (!rst_n)
    !healthy_r |-> stall_r == STALL_DEAD)
    else $error("stall count inconsistent with encoder health");

endmodule

// File: tb/motor_velocity_pid_controller_unit_tb.sv
// Self-checking testbench for the motor velocity PID controller unit.
module motor_velocity_pid_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_SCALE = 4200;
  localparam int STALL_MAX = 100;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [5:0]         pad;
    logic signed [15:0] velocity_now;
    logic               loop_closed;
    logic               encoder_healthy;
    logic               overspeed_flag;
    logic [2:0]         speed_level;
    logic               turn_clockwise;
    logic signed [13:0] drive_level;
    logic [12:0]        compare_value;
  } motor_status_t;

  typedef struct {
    mvpc_pkg::kind_t kind;
    logic [15:0]     cmd;
    logic [15:0]     delta;
    bit              typed;
    logic [55:0]     status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  motor_velocity_pid_controller_unit uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint accel_q, scale_q, kp, ki, kd;
  longint ramp_vel, goal_vel, drive_acc, err_1, err_2, stall_cnt, held_drv, held_lvl;
  bit f_healthy, f_closed, f_cw, f_over;

  logic [55:0] status_fifo[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  longint cycles = 0;

  function automatic longint floor16(longint r);
    return (r >= 0) ? r / 65536 : -((-r + 65535) / 65536);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wrap32(longint v);
    return longint'($signed(v[31:0]));
  endfunction

  task automatic controller_reset();
    accel_q = 100; kp = 0; ki = 0; kd = 0; scale_q = 16384;
    ramp_vel = 0; goal_vel = 0; drive_acc = 0; err_1 = 0; err_2 = 0;
    stall_cnt = 0; held_drv = 0; held_lvl = 0;
    f_healthy = 1; f_closed = 0; f_cw = 1; f_over = 0;
  endtask

  function automatic void controller_tick(longint dlt);
    longint a, stp, goal, diff, mag, e, pid, d, m;
    bit closed, healthy;
    closed = f_closed;
    healthy = f_healthy;
    a = (accel_q == 0) ? 1 : accel_q;
    stp = (a * 65536) / 1000;
    goal = goal_vel * 65536;
    diff = goal - ramp_vel;
    mag = diff < 0 ? -diff : diff;
    if (mag > stp) ramp_vel = wrap32(ramp_vel + (diff > 0 ? stp : -stp));
    else ramp_vel = wrap32(goal);
    e = floor16(ramp_vel) - dlt;
    pid = (kp * (e - err_1) + ki * e + kd * (e + err_2 - 2 * err_1)) * 256;
    if (closed && healthy) begin
      if (floor16(ramp_vel) != 0 && dlt == 0) begin
        stall_cnt++;
        f_healthy = (stall_cnt <= STALL_MAX);
      end else begin
        stall_cnt = 0;
      end
      drive_acc = clip32(drive_acc + pid);
    end else begin
      if (closed && !healthy) drive_acc = 0;
      if (healthy) begin
        goal_vel = dlt;
        ramp_vel = wrap32(dlt * 65536);
      end
      if (!healthy && dlt != 0) begin
        stall_cnt = 0;
        f_healthy = 1;
      end
    end
    err_2 = err_1;
    err_1 = floor16(ramp_vel) - dlt;
    d = (floor16(drive_acc) * scale_q) / 16384;
    m = d < 0 ? -d : d;
    if (m <= 419) held_lvl = 0;
    else if (m <= 1259) held_lvl = 1;
    else if (m <= 2099) held_lvl = 2;
    else if (m <= 2939) held_lvl = 3;
    else if (m <= 3779) held_lvl = 4;
    else if (m <= 4199) held_lvl = 5;
    else begin
      held_lvl = mvpc_pkg::LEVEL_OVER;
      f_over = 1;
      d = d < 0 ? -FULL_SCALE : FULL_SCALE;
    end
    if (d > 0) f_cw = 1;
    else if (d < 0) f_cw = 0;
    held_drv = d;
  endfunction

  function automatic logic [55:0] controller_apply(mvpc_pkg::kind_t k, logic [15:0] c,
                                                   logic [15:0] dl);
    motor_status_t s;
    longint mg;
    case (k)
      mvpc_pkg::KIND_TICK: controller_tick(longint'($signed(dl)));
      mvpc_pkg::KIND_TARGET: begin
        goal_vel = longint'($signed(c));
        f_closed = 1;
      end
      mvpc_pkg::KIND_OPEN: begin
        drive_acc = longint'($signed(c)) * 65536;
        f_closed = 0;
      end
      default: begin
        goal_vel = 0;
        ramp_vel = 0;
        f_closed = 1;
      end
    endcase
    mg = held_drv < 0 ? -held_drv : held_drv;
    if (mg > FULL_SCALE) mg = FULL_SCALE;
    s = '0;
    s.compare_value = 13'(FULL_SCALE - mg);
    s.drive_level = 14'(held_drv);
    s.turn_clockwise = f_cw;
    s.speed_level = 3'(held_lvl);
    s.overspeed_flag = f_over;
    s.encoder_healthy = f_healthy;
    s.loop_closed = f_closed;
    s.velocity_now = 16'(floor16(ramp_vel));
    return s;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      mvpc_pkg::REG_ACCEL: accel_q = val;
      mvpc_pkg::REG_GAIN_P: kp = longint'($signed(val));
      mvpc_pkg::REG_GAIN_I: ki = longint'($signed(val));
      mvpc_pkg::REG_GAIN_D: kd = longint'($signed(val));
      mvpc_pkg::REG_SCALE: scale_q = val;
      default: ;
    endcase
  endtask

  task automatic send_request(mvpc_pkg::kind_t k, logic [15:0] c, logic [15:0] dl, bit typed,
                              logic [55:0] status);
    logic [55:0] predicted;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= {dl, c};
    do @(posedge clk); while (!in_tready);
    predicted = controller_apply(k, c, dl);
    if (typed && predicted !== status)
      $display("%0t predictor disagrees with table: %h vs %h", $time, status, predicted);
    status_fifo.push_back(typed ? status : predicted);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (status_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
    if (rst_n && out_tvalid && out_tready) begin
      if (status_fifo.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, out_tdata);
        errors++;
      end else begin
        logic [55:0] want;
        want = status_fifo.pop_front();
        if (out_tdata !== want) begin
          $display("%0t mismatch: expected %h actual %h", $time, want, out_tdata);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic mvpc_pkg::kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 70) return mvpc_pkg::KIND_TICK;
    if (r < 85) return mvpc_pkg::KIND_TARGET;
    if (r < 95) return mvpc_pkg::KIND_OPEN;
    return mvpc_pkg::KIND_LOCK;
  endfunction

  function automatic logic [15:0] rand_small();
    return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(400)) - 200);
  endfunction

  stim_row_t directed[$];

  initial begin
    motor_status_t s0;
    controller_reset();
    s0 = '0;
    s0.compare_value = 13'(FULL_SCALE);
    s0.turn_clockwise = 1'b1;
    s0.encoder_healthy = 1'b1;
    s0.loop_closed = 1'b1;
    directed.push_back('{mvpc_pkg::KIND_TARGET, 16'h0000, 16'hFFFF, 1'b1, 56'(s0)});
    directed.push_back('{mvpc_pkg::KIND_LOCK, 16'h1234, 16'h8000, 1'b1, 56'(s0)});
    directed.push_back('{mvpc_pkg::KIND_TARGET, 16'h7FFF, 16'h0000, 1'b0, '0});
    directed.push_back('{mvpc_pkg::KIND_TICK, 16'h0000, 16'h0000, 1'b0, '0});
    directed.push_back('{mvpc_pkg::KIND_TICK, 16'hFFFF, 16'h7FFF, 1'b0, '0});
    directed.push_back('{mvpc_pkg::KIND_TICK, 16'h0000, 16'h8000, 1'b0, '0});
    directed.push_back('{mvpc_pkg::KIND_OPEN, 16'h7FFF, 16'h0000, 1'b0, '0});
    directed.push_back('{mvpc_pkg::KIND_TICK, 16'h0000, 16'h0005, 1'b0, '0});
    directed.push_back('{mvpc_pkg::KIND_OPEN, 16'h8000, 16'h0000, 1'b0, '0});
    directed.push_back('{mvpc_pkg::KIND_TICK, 16'h0000, 16'hFFF0, 1'b0, '0});
    directed.push_back('{mvpc_pkg::KIND_OPEN, 16'h0000, 16'h0000, 1'b0, '0});
    directed.push_back('{mvpc_pkg::KIND_TICK, 16'h0000, 16'h0000, 1'b0, '0});
    directed.push_back('{mvpc_pkg::KIND_TARGET, 16'h8000, 16'h0000, 1'b0, '0});
    for (int i = 0; i < 8; i++)
      directed.push_back('{mvpc_pkg::KIND_TICK, 16'h0, 16'h0, 1'b0, '0});
    directed.push_back('{mvpc_pkg::KIND_LOCK, 16'h0000, 16'h0000, 1'b0, '0});
    directed.push_back('{mvpc_pkg::KIND_TICK, 16'h0000, 16'h0003, 1'b0, '0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(3'd7, 16'hFFFF);

    foreach (directed[i])
      send_request(directed[i].kind, directed[i].cmd, directed[i].delta,
                   directed[i].typed, directed[i].status);
    drain();

    // stall timeout: closed loop, ramping, no encoder motion
    write_reg(mvpc_pkg::REG_ACCEL, 16'hFFFF);
    send_request(mvpc_pkg::KIND_TARGET, 16'd50, 16'd0, 1'b0, '0);
    for (int i = 0; i < STALL_MAX + 5; i++)
      send_request(mvpc_pkg::KIND_TICK, 16'($urandom), 16'd0, 1'b0, '0);
    send_request(mvpc_pkg::KIND_TICK, 16'd0, 16'd9, 1'b0, '0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 50; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 50; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      write_reg(mvpc_pkg::REG_ACCEL,
                (phase == 0) ? 16'hFFFF : (phase == 5) ? 16'd0 : 16'($urandom));
      write_reg(mvpc_pkg::REG_GAIN_P,
                (phase == 1) ? 16'h7FFF : (phase == 6) ? 16'h8000 : 16'($urandom_range(1024)));
      write_reg(mvpc_pkg::REG_GAIN_I,
                (phase == 2) ? 16'h8000 : (phase == 7) ? 16'h7FFF : 16'($urandom));
      write_reg(mvpc_pkg::REG_GAIN_D, (phase == 3) ? 16'h7FFF : 16'($urandom));
      write_reg(mvpc_pkg::REG_SCALE,
                (phase == 4) ? 16'hFFFF : (phase == 5) ? 16'h0000 : 16'($urandom));
      for (int n = 0; n < 125; n++) begin
        mvpc_pkg::kind_t k;
        k = pick_kind();
        send_request(k, rand_small(),
                     ($urandom_range(9) == 0) ? 16'd0 : rand_small(), 1'b0, '0);
        if (n == 60 && phase == 2) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/mvpc_pkg.sv
hdl/mvpc_mul.sv
hdl/motor_velocity_pid_controller_unit.sv
tb/motor_velocity_pid_controller_unit_tb.sv
